FILE: hw/rtl/hsh_pkg.sv
// Shared constants and controller/datapath command and status types for the hue-sat histogram.
package hsh_pkg;

	localparam int HUE_BINS    = 16;
	localparam int SAT_BINS    = 8;
	localparam int COUNT_WIDTH = 24;
	localparam int HUE_RANGE   = 180;
	localparam int SAT_RANGE   = 256;
	localparam int NUM_BINS    = HUE_BINS * SAT_BINS;

	// fixed field widths
	localparam int KIND_W  = 2;
	localparam int HUE_W   = 8;
	localparam int SAT_W   = 8;
	localparam int IDX_W   = 7;
	localparam int FRAC_W  = 17;
	localparam int BIN_W   = $clog2(NUM_BINS);
	localparam int IN_W    = 24;
	localparam int OUT_W   = 72;

	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [FRAC_W-1:0]      ONE_Q16   = 17'h10000;

	// hue bin: floor(x / HUE_RANGE) as (x * HUE_MUL) >> HUE_SHIFT, x = hue * HUE_BINS
	localparam int HUE_X_W   = $clog2(SAT_RANGE * HUE_BINS);
	localparam int HUE_SHIFT = HUE_X_W + 8;
	localparam int HUE_MUL   = (2 ** HUE_SHIFT + HUE_RANGE - 1) / HUE_RANGE;
	localparam int HUE_MUL_W = HUE_SHIFT - 6;
	localparam int HUE_P_W   = HUE_X_W + HUE_MUL_W;
	localparam int HUE_B_W   = HUE_P_W - HUE_SHIFT;

	// sat bin: (sat * SAT_BINS) >> 8
	localparam int SAT_X_W = SAT_W + 1 + $clog2(SAT_BINS);
	localparam int SAT_B_W = SAT_X_W - SAT_W;

	// long division: quotient bits of count * 2^16 + total / 2 over total
	localparam int QBITS  = FRAC_W;
	localparam int STEP_W = $clog2(QBITS);
	localparam int NUM_W  = COUNT_WIDTH + 17;

	typedef struct packed {
		logic pix_acc;   // pixel word taken: read bin, bump total
		logic rd_acc;    // read word taken: read requested bin
		logic clr;       // clear word taken
		logic upd;       // write back incremented bin
		logic div_init;  // load divider from read data
		logic div_step;  // one quotient bit
		logic out_load;  // move result into output register
	} cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} sts_t;

endpackage

FILE: hw/rtl/hsh_ctrl.sv
// Controller state machine for the hue-sat histogram.
module hsh_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [hsh_pkg::KIND_W-1:0] kind,
	output logic                      s_tready,
	input  hsh_pkg::sts_t             sts,
	output hsh_pkg::cmd_t             cmd
);

	typedef enum logic [2:0] {ST_IDLE, ST_UPD, ST_LOAD, ST_DIV, ST_DONE} state_t;

	state_t                     state_q;
	logic [hsh_pkg::STEP_W-1:0] step_q;
	logic                       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tready && s_tvalid;

	always_comb begin
		cmd          = '0;
		cmd.pix_acc  = accept && (kind == hsh_pkg::KIND_PIXEL);
		cmd.rd_acc   = accept && (kind == hsh_pkg::KIND_READ);
		cmd.clr      = accept && (kind == hsh_pkg::KIND_CLEAR);
		cmd.upd      = (state_q == ST_UPD);
		cmd.div_init = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.pix_acc)
						state_q <= ST_UPD;
					else if (cmd.rd_acc)
						state_q <= ST_LOAD;
				end
				ST_UPD: state_q <= ST_IDLE;
				ST_LOAD: begin
					step_q  <= hsh_pkg::STEP_W'(hsh_pkg::QBITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0)
						state_q <= ST_DONE;
					else
						step_q <= step_q - 1'b1;
				end
				ST_DONE: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/hsh_dp.sv
// Datapath: bin memory, pixel total, restoring divider and output register.
module hsh_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hsh_pkg::cmd_t                  cmd,
	input  logic [hsh_pkg::HUE_W-1:0]      hue,
	input  logic [hsh_pkg::SAT_W-1:0]      sat,
	input  logic [hsh_pkg::IDX_W-1:0]      bin_index,
	output hsh_pkg::sts_t                  sts,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hsh_pkg::COUNT_WIDTH-1:0] bin_count,
	output logic [hsh_pkg::FRAC_W-1:0]     bin_fraction,
	output logic [hsh_pkg::COUNT_WIDTH-1:0] pixel_total
);

	localparam int CW = hsh_pkg::COUNT_WIDTH;
	localparam int BW = hsh_pkg::BIN_W;

	logic [CW-1:0]  mem [hsh_pkg::NUM_BINS];
	logic [hsh_pkg::NUM_BINS-1:0] vld_q;
	logic [CW-1:0]  rd_q;
	logic           rvalid_q;
	logic [BW-1:0]  addr_q;
	logic [CW-1:0]  total_q;

	// bin mapping
	logic [hsh_pkg::HUE_P_W-1:0] hprod;
	logic [hsh_pkg::HUE_B_W-1:0] hb_raw;
	logic [hsh_pkg::HUE_B_W-1:0] hb;
	logic [hsh_pkg::SAT_X_W-1:0] sprod;
	logic [hsh_pkg::SAT_B_W-1:0] sb_raw;
	logic [hsh_pkg::SAT_B_W-1:0] sb;
	logic [BW-1:0]               pix_bin;
	logic [BW-1:0]               raddr;
	logic                        idx_ok;

	assign hprod  = hsh_pkg::HUE_P_W'(hue) * hsh_pkg::HUE_P_W'(hsh_pkg::HUE_BINS)
	              * hsh_pkg::HUE_P_W'(hsh_pkg::HUE_MUL);
	assign hb_raw = hprod[hsh_pkg::HUE_P_W-1:hsh_pkg::HUE_SHIFT];
	assign hb     = (hb_raw >= hsh_pkg::HUE_B_W'(hsh_pkg::HUE_BINS))
	              ? hsh_pkg::HUE_B_W'(hsh_pkg::HUE_BINS - 1) : hb_raw;
	assign sprod  = hsh_pkg::SAT_X_W'(sat) * hsh_pkg::SAT_X_W'(hsh_pkg::SAT_BINS);
	assign sb_raw = sprod[hsh_pkg::SAT_X_W-1:hsh_pkg::SAT_W];
	assign sb     = (sb_raw >= hsh_pkg::SAT_B_W'(hsh_pkg::SAT_BINS))
	              ? hsh_pkg::SAT_B_W'(hsh_pkg::SAT_BINS - 1) : sb_raw;
	assign pix_bin = BW'(BW'(hb) * BW'(hsh_pkg::SAT_BINS) + BW'(sb));
	assign idx_ok  = ({1'b0, bin_index} < (hsh_pkg::IDX_W + 1)'(hsh_pkg::NUM_BINS));
	assign raddr   = cmd.pix_acc ? pix_bin : BW'(bin_index);

	// saturating increment of the bin just read
	logic [CW-1:0] cur;
	logic [CW-1:0] inc;
	assign cur = rvalid_q ? rd_q : '0;
	assign inc = (cur == hsh_pkg::COUNT_MAX) ? cur : cur + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.upd)
			mem[addr_q] <= inc;
		if (cmd.pix_acc || cmd.rd_acc) begin
			rd_q     <= mem[raddr];
			rvalid_q <= vld_q[raddr] && (cmd.pix_acc || idx_ok);
			addr_q   <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.clr) begin
				vld_q   <= '0;
				total_q <= '0;
			end else begin
				if (cmd.upd)
					vld_q[addr_q] <= 1'b1;
				if (cmd.pix_acc && total_q != hsh_pkg::COUNT_MAX)
					total_q <= total_q + 1'b1;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  rem_q;
	logic [hsh_pkg::QBITS-1:0]      dvd_q;
	logic [hsh_pkg::QBITS-1:0]      quo_q;
	logic [hsh_pkg::NUM_W-1:0]      num;
	logic [CW:0]                    trial;
	logic                           ge;
	logic [CW:0]                    diff;

	assign num   = {1'b0, cur, 16'b0} + hsh_pkg::NUM_W'(total_q[CW-1:1]);
	assign trial = {rem_q, dvd_q[hsh_pkg::QBITS-1]};
	assign ge    = (trial >= {1'b0, total_q});
	assign diff  = trial - {1'b0, total_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			cnt_q <= cur;
			rem_q <= num[hsh_pkg::NUM_W-1:hsh_pkg::QBITS];
			dvd_q <= num[hsh_pkg::QBITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			dvd_q <= {dvd_q[hsh_pkg::QBITS-2:0], 1'b0};
			quo_q <= {quo_q[hsh_pkg::QBITS-2:0], ge};
		end
	end

	// output register
	logic                     out_valid_q;
	logic [CW-1:0]            out_cnt_q;
	logic [hsh_pkg::FRAC_W-1:0] out_frac_q;
	logic [CW-1:0]            out_tot_q;
	logic [hsh_pkg::FRAC_W-1:0] frac;

	assign frac = (total_q == '0) ? '0
	            : (quo_q > hsh_pkg::ONE_Q16) ? hsh_pkg::ONE_Q16 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cnt_q  <= cnt_q;
			out_frac_q <= frac;
			out_tot_q  <= total_q;
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign bin_count    = out_cnt_q;
	assign bin_fraction = out_frac_q;
	assign pixel_total  = out_tot_q;

endmodule

FILE: hw/rtl/hue_sat_histogram_top.sv
// Top level of the 16x8 hue-saturation histogram with normalized bin read.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: kind; tdata: hue, sat, bin_index
//  m_       out  m_tvalid/m_tready  tdata: bin_count, bin_fraction, pixel_total
//
// Pixel word: bin read, then increment and write back on one memory port.
// Clear word: the per-bin valid flags drop at once, no sweep.
// Read word: bin read, divider load, the 17-step restoring divider, then output load, plus any wait for m_tready.
// Reset empties the histogram immediately.
// A finished result sits in the output register; new words are taken while it waits.
module hue_sat_histogram_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hue[7:0], sat[15:8], bin_index[22:16], zero pad
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // bin_count[23:0], bin_fraction[40:24], pixel_total[64:41]
);

	hsh_pkg::cmd_t cmd;
	hsh_pkg::sts_t sts;

	logic [hsh_pkg::COUNT_WIDTH-1:0] bin_count;
	logic [hsh_pkg::FRAC_W-1:0]      bin_fraction;
	logic [hsh_pkg::COUNT_WIDTH-1:0] pixel_total;

	hsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hsh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.hue          (s_tdata[7:0]),
		.sat          (s_tdata[15:8]),
		.bin_index    (s_tdata[22:16]),
		.sts          (sts),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.bin_count    (bin_count),
		.bin_fraction (bin_fraction),
		.pixel_total  (pixel_total)
	);

	assign m_tdata = {7'b0, pixel_total, bin_fraction, bin_count};

	// a bin can never hold more than the total
	a_count_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (bin_count <= pixel_total))
		else $error("bin count above pixel total");

	a_frac_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (bin_fraction <= hsh_pkg::ONE_Q16))
		else $error("fraction above one");

	a_empty_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && pixel_total == '0) |-> (bin_fraction == '0 && bin_count == '0))
		else $error("nonzero result from empty histogram");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pix_acc, cmd.rd_acc, cmd.clr, cmd.upd, cmd.div_init, cmd.div_step,
			cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule
